// ===== sv/scf_pkg.sv =====
`default_nettype none
package scf_pkg;

  // Stream and configuration widths
  localparam int IN_W       = 352;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Squared distance width and root width
  localparam int SQ_W   = 62;
  localparam int ROOT_W = 31;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [8:0]  MAX_DEG = 9'd360;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_FACTION   = 3'd0,
    REG_INTEREST_MASK = 3'd1,
    REG_SIGHT_RANGE   = 3'd2,
    REG_ACUITY        = 3'd3,
    REG_VIEW_ANGLE    = 3'd4,
    REG_FLOOR_CONF    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_UNINTERESTING = 2'd0,
    VERDICT_OUT_OF_RANGE  = 2'd1,
    VERDICT_OUTSIDE_CONE  = 2'd2,
    VERDICT_CANDIDATE     = 2'd3
  } verdict_t;

  // Configuration as seen by the datapath, already clamped
  typedef struct packed {
    logic [31:0] self_faction;
    logic [31:0] interest_mask;
    logic [30:0] view_range;
    logic [16:0] acuity;
    logic [16:0] floor_conf;
    logic [16:0] cos_mag;
    logic        cos_neg;
  } cfg_t;

  // Cosine of whole degrees 0..90, Q16
  function automatic logic [16:0] cos_deg_q16(input logic [6:0] deg);
    logic [16:0] c;
    unique case (deg)
      7'd0: c = 17'd65536;  7'd1: c = 17'd65526;  7'd2: c = 17'd65496;
      7'd3: c = 17'd65446;  7'd4: c = 17'd65376;  7'd5: c = 17'd65287;
      7'd6: c = 17'd65177;  7'd7: c = 17'd65048;  7'd8: c = 17'd64898;
      7'd9: c = 17'd64729;  7'd10: c = 17'd64540; 7'd11: c = 17'd64332;
      7'd12: c = 17'd64104; 7'd13: c = 17'd63856; 7'd14: c = 17'd63589;
      7'd15: c = 17'd63303; 7'd16: c = 17'd62997; 7'd17: c = 17'd62672;
      7'd18: c = 17'd62328; 7'd19: c = 17'd61966; 7'd20: c = 17'd61584;
      7'd21: c = 17'd61183; 7'd22: c = 17'd60764; 7'd23: c = 17'd60326;
      7'd24: c = 17'd59870; 7'd25: c = 17'd59396; 7'd26: c = 17'd58903;
      7'd27: c = 17'd58393; 7'd28: c = 17'd57865; 7'd29: c = 17'd57319;
      7'd30: c = 17'd56756; 7'd31: c = 17'd56175; 7'd32: c = 17'd55578;
      7'd33: c = 17'd54963; 7'd34: c = 17'd54332; 7'd35: c = 17'd53684;
      7'd36: c = 17'd53020; 7'd37: c = 17'd52339; 7'd38: c = 17'd51643;
      7'd39: c = 17'd50931; 7'd40: c = 17'd50203; 7'd41: c = 17'd49461;
      7'd42: c = 17'd48703; 7'd43: c = 17'd47930; 7'd44: c = 17'd47143;
      7'd45: c = 17'd46341; 7'd46: c = 17'd45525; 7'd47: c = 17'd44695;
      7'd48: c = 17'd43852; 7'd49: c = 17'd42995; 7'd50: c = 17'd42126;
      7'd51: c = 17'd41243; 7'd52: c = 17'd40348; 7'd53: c = 17'd39441;
      7'd54: c = 17'd38521; 7'd55: c = 17'd37590; 7'd56: c = 17'd36647;
      7'd57: c = 17'd35693; 7'd58: c = 17'd34729; 7'd59: c = 17'd33754;
      7'd60: c = 17'd32768; 7'd61: c = 17'd31772; 7'd62: c = 17'd30767;
      7'd63: c = 17'd29753; 7'd64: c = 17'd28729; 7'd65: c = 17'd27697;
      7'd66: c = 17'd26656; 7'd67: c = 17'd25607; 7'd68: c = 17'd24550;
      7'd69: c = 17'd23486; 7'd70: c = 17'd22415; 7'd71: c = 17'd21336;
      7'd72: c = 17'd20252; 7'd73: c = 17'd19161; 7'd74: c = 17'd18064;
      7'd75: c = 17'd16962; 7'd76: c = 17'd15855; 7'd77: c = 17'd14742;
      7'd78: c = 17'd13626; 7'd79: c = 17'd12505; 7'd80: c = 17'd11380;
      7'd81: c = 17'd10252; 7'd82: c = 17'd9121;  7'd83: c = 17'd7987;
      7'd84: c = 17'd6850;  7'd85: c = 17'd5712;  7'd86: c = 17'd4572;
      7'd87: c = 17'd3430;  7'd88: c = 17'd2287;  7'd89: c = 17'd1144;
      default: c = 17'd0;
    endcase
    return c;
  endfunction

  // Right shift that brings the larger magnitude below 2^15
  function automatic logic [4:0] norm_shift(input logic [32:0] v);
    logic [4:0] s;
    s = '0;
    for (int i = 15; i < 33; i++) begin
      if (v[i]) s = 5'(i - 14);
    end
    return s;
  endfunction

  // Shift a magnitude and put the sign back
  function automatic logic [15:0] reduce_comp(input logic [32:0] m, input logic neg,
                                              input logic [4:0] s);
    logic [32:0] t;
    logic [15:0] u;
    t = m >> s;
    u = {1'b0, t[14:0]};
    return neg ? 16'(-u) : u;
  endfunction

endpackage
`default_nettype wire

// ===== sv/scf_front.sv =====
`default_nettype none
module scf_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    adv,
  input  wire scf_pkg::cfg_t     cfg,
  input  wire                    in_valid,
  input  wire [scf_pkg::IN_W-1:0] in_data,
  output logic                   out_valid,
  output scf_pkg::verdict_t      out_verdict,
  output logic [scf_pkg::SQ_W-1:0] out_sq
);
  import scf_pkg::*;

  // Input fields
  logic [63:0] oid, tid;
  logic [31:0] ox, oz, fx, fz, tx, tz, tfac;
  assign oid  = in_data[63:0];
  assign ox   = in_data[95:64];
  assign oz   = in_data[127:96];
  assign fx   = in_data[159:128];
  assign fz   = in_data[191:160];
  assign tid  = in_data[255:192];
  assign tx   = in_data[287:256];
  assign tz   = in_data[319:288];
  assign tfac = in_data[351:320];

  logic v1, v2, v3, v4, v5, v6;
  logic rej1, rej2, rej3, rej4, rej5, rej6;
  logic zero2, zero3, zero4, zero5, zero6;
  logic oor3, oor4, oor5, oor6;
  logic [32:0] dx1, dz1;
  logic [31:0] fx1, fz1;
  logic [65:0] sqx2, sqz2;
  logic [15:0] rfx2, rfz2, rox2, roz2;
  logic [SQ_W-1:0] sq3, sq4, sq5, sq6;
  logic [31:0] pd0_3, pd1_3;
  logic [29:0] lf0_3, lf1_3, lo0_3, lo1_3;
  logic [31:0] dot4;
  logic [30:0] lf4, lo4;
  logic [32:0] csq4, csq5;
  logic        dnn5, dnn6;
  logic [63:0] d2_5, d2_6;
  logic [61:0] p5;
  logic [63:0] rlo6, rhi6;

  // Stage 1: interest test and offset
  logic rej_c;
  assign rej_c = (oid == tid) || (tfac == cfg.self_faction) ||
                 ((cfg.interest_mask & tfac) == 32'd0);

  // Stage 2: magnitudes, squares and component reduction
  logic [32:0] mdx, mdz, mfx, mfz;
  logic [4:0]  sf, so;
  assign mdx = dx1[32] ? 33'(-dx1) : dx1;
  assign mdz = dz1[32] ? 33'(-dz1) : dz1;
  assign mfx = {1'b0, fx1[31] ? 32'(-fx1) : fx1};
  assign mfz = {1'b0, fz1[31] ? 32'(-fz1) : fz1};
  assign sf  = norm_shift(mfx | mfz);
  assign so  = norm_shift(mdx | mdz);

  // Stage 3: range compare and small products
  logic [66:0] sq_sum;
  logic [61:0] rsq;
  assign sq_sum = {1'b0, sqx2} + {1'b0, sqz2};
  assign rsq    = {31'd0, cfg.view_range} * {31'd0, cfg.view_range};

  // Stage 7: cone decision
  logic [95:0] lhs, rhs;
  logic        cone_ok;
  assign lhs = {d2_6, 32'd0};
  assign rhs = ({32'd0, rhi6} << 31) + {32'd0, rlo6};
  always_comb begin
    if (zero6)             cone_ok = 1'b1;
    else if (cfg.cos_neg)  cone_ok = dnn6 || (lhs <= rhs);
    else                   cone_ok = dnn6 && (lhs >= rhs);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; out_valid <= v6;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      rej1 <= rej_c;
      dx1  <= {tx[31], tx} - {ox[31], ox};
      dz1  <= {tz[31], tz} - {oz[31], oz};
      fx1  <= fx;
      fz1  <= fz;

      rej2  <= rej1;
      zero2 <= ((fx1 == 32'd0) && (fz1 == 32'd0)) || ((dx1 == 33'd0) && (dz1 == 33'd0));
      sqx2  <= {33'd0, mdx} * {33'd0, mdx};
      sqz2  <= {33'd0, mdz} * {33'd0, mdz};
      rfx2  <= reduce_comp(mfx, fx1[31], sf);
      rfz2  <= reduce_comp(mfz, fz1[31], sf);
      rox2  <= reduce_comp(mdx, dx1[32], so);
      roz2  <= reduce_comp(mdz, dz1[32], so);

      rej3  <= rej2;
      zero3 <= zero2;
      oor3  <= sq_sum > {5'd0, rsq};
      sq3   <= sq_sum[SQ_W-1:0];
      pd0_3 <= 32'($signed(rfx2) * $signed(rox2));
      pd1_3 <= 32'($signed(rfz2) * $signed(roz2));
      lf0_3 <= 30'($signed(rfx2) * $signed(rfx2));
      lf1_3 <= 30'($signed(rfz2) * $signed(rfz2));
      lo0_3 <= 30'($signed(rox2) * $signed(rox2));
      lo1_3 <= 30'($signed(roz2) * $signed(roz2));

      rej4  <= rej3;
      zero4 <= zero3;
      oor4  <= oor3;
      sq4   <= sq3;
      dot4  <= pd0_3 + pd1_3;
      lf4   <= {1'b0, lf0_3} + {1'b0, lf1_3};
      lo4   <= {1'b0, lo0_3} + {1'b0, lo1_3};
      csq4  <= 33'({16'd0, cfg.cos_mag} * {16'd0, cfg.cos_mag});

      rej5  <= rej4;
      zero5 <= zero4;
      oor5  <= oor4;
      sq5   <= sq4;
      csq5  <= csq4;
      dnn5  <= !dot4[31];
      d2_5  <= {32'd0, dot4[31] ? 32'(-dot4) : dot4} *
               {32'd0, dot4[31] ? 32'(-dot4) : dot4};
      p5    <= {31'd0, lf4} * {31'd0, lo4};

      rej6  <= rej5;
      zero6 <= zero5;
      oor6  <= oor5;
      sq6   <= sq5;
      dnn6  <= dnn5;
      d2_6  <= d2_5;
      rlo6  <= {31'd0, csq5} * {33'd0, p5[30:0]};
      rhi6  <= {31'd0, csq5} * {33'd0, p5[61:31]};

      out_sq <= sq6;
      if (rej6)          out_verdict <= VERDICT_UNINTERESTING;
      else if (oor6)     out_verdict <= VERDICT_OUT_OF_RANGE;
      else if (!cone_ok) out_verdict <= VERDICT_OUTSIDE_CONE;
      else               out_verdict <= VERDICT_CANDIDATE;
    end
  end

endmodule
`default_nettype wire

// ===== sv/scf_isqrt.sv =====
`default_nettype none
module scf_isqrt #(
  parameter int VAL_W = scf_pkg::SQ_W,
  parameter int TAG_W = 2
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 adv,
  input  wire                 in_valid,
  input  wire [VAL_W-1:0]     in_val,
  input  wire [TAG_W-1:0]     in_tag,
  output logic                out_valid,
  output logic [VAL_W/2-1:0]  out_root,
  output logic [TAG_W-1:0]    out_tag
);
  import scf_pkg::*;

  localparam int RES_W = VAL_W / 2;

  logic             vld    [RES_W];
  logic [VAL_W-1:0] rem_q  [RES_W];
  logic [RES_W-1:0] root_q [RES_W];
  logic [TAG_W-1:0] tag_q  [RES_W];

  // One root bit per stage, most significant first
  for (genvar k = 0; k < RES_W; k++) begin : g_bit
    localparam int B = RES_W - 1 - k;
    logic             vin;
    logic [VAL_W-1:0] rem_in;
    logic [RES_W-1:0] root_in;
    logic [TAG_W-1:0] tag_in;
    logic [VAL_W:0]   trial;

    if (k == 0) begin : g_first
      assign vin     = in_valid;
      assign rem_in  = in_val;
      assign root_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign vin     = vld[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    // Trial subtrahend: 2*r*2^B + 2^(2B)
    assign trial = ({{(VAL_W+1-RES_W){1'b0}}, root_in} << (B + 1)) +
                   ((VAL_W+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (adv) vld[k] <= vin;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tag_q[k] <= tag_in;
        if ({1'b0, rem_in} >= trial) begin
          rem_q[k]  <= rem_in - trial[VAL_W-1:0];
          root_q[k] <= root_in | (RES_W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign out_valid = vld[RES_W-1];
  assign out_root  = root_q[RES_W-1];
  assign out_tag   = tag_q[RES_W-1];

endmodule
`default_nettype wire

// ===== sv/scf_falloff.sv =====
`default_nettype none
module scf_falloff (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      adv,
  input  wire scf_pkg::cfg_t       cfg,
  input  wire                      in_valid,
  input  wire [scf_pkg::ROOT_W-1:0] in_dist,
  input  wire scf_pkg::verdict_t   in_verdict,
  output logic                     out_valid,
  output scf_pkg::verdict_t        out_verdict,
  output logic [16:0]              out_conf
);
  import scf_pkg::*;

  localparam int Q_W   = 17;
  localparam int NUM_W = ROOT_W + Q_W;

  // Stage A: acute distance
  logic              va, vb;
  verdict_t          verd_a, verd_b;
  logic [ROOT_W-1:0] dist_a, acute_a;
  logic [47:0]       acute_prod;
  assign acute_prod = {17'd0, cfg.view_range} * {31'd0, cfg.acuity};

  // Stage B: numerator and divisor
  logic              full_b;
  logic [NUM_W-1:0]  num_b;
  logic [ROOT_W-1:0] den_b;
  logic [ROOT_W-1:0] over_a;
  logic [16:0]       span;
  assign over_a = dist_a - acute_a;
  assign span   = ONE_Q16 - cfg.floor_conf;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verd_a  <= in_verdict;
      dist_a  <= in_dist;
      acute_a <= acute_prod[16 +: ROOT_W];
      verd_b  <= verd_a;
      full_b  <= (dist_a <= acute_a) || (cfg.view_range <= acute_a);
      num_b   <= {{Q_W{1'b0}}, over_a} * {{ROOT_W{1'b0}}, span};
      den_b   <= cfg.view_range - acute_a;
    end
  end

  // Restoring divider, one quotient bit per stage
  logic              dv   [Q_W];
  verdict_t          dverd[Q_W];
  logic              dfull[Q_W];
  logic [NUM_W-1:0]  drem [Q_W];
  logic [ROOT_W-1:0] dden [Q_W];
  logic [Q_W-1:0]    dq   [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int B = Q_W - 1 - k;
    logic              vin;
    verdict_t          verd_in;
    logic              full_in;
    logic [NUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [Q_W-1:0]    q_in;
    logic [NUM_W-1:0]  sub;

    if (k == 0) begin : g_first
      assign vin     = vb;
      assign verd_in = verd_b;
      assign full_in = full_b;
      assign rem_in  = num_b;
      assign den_in  = den_b;
      assign q_in    = '0;
    end else begin : g_next
      assign vin     = dv[k-1];
      assign verd_in = dverd[k-1];
      assign full_in = dfull[k-1];
      assign rem_in  = drem[k-1];
      assign den_in  = dden[k-1];
      assign q_in    = dq[k-1];
    end

    assign sub = {{Q_W{1'b0}}, den_in} << B;

    always_ff @(posedge clk) begin
      if (rst) dv[k] <= 1'b0;
      else if (adv) dv[k] <= vin;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dverd[k] <= verd_in;
        dfull[k] <= full_in;
        dden[k]  <= den_in;
        if (rem_in >= sub) begin
          drem[k] <= rem_in - sub;
          dq[k]   <= q_in | (Q_W'(1) << B);
        end else begin
          drem[k] <= rem_in;
          dq[k]   <= q_in;
        end
      end
    end
  end

  // Final confidence
  logic [16:0] drop;
  assign drop = (dq[Q_W-1] > ONE_Q16) ? ONE_Q16 : dq[Q_W-1];

  assign out_valid   = dv[Q_W-1];
  assign out_verdict = dverd[Q_W-1];
  always_comb begin
    if (dverd[Q_W-1] != VERDICT_CANDIDATE) out_conf = 17'd0;
    else if (dfull[Q_W-1])                 out_conf = ONE_Q16;
    else                                   out_conf = ONE_Q16 - drop;
  end

endmodule
`default_nettype wire

// ===== sv/sight_cone_filter_top.sv =====
// An accepted item passes through the front, square-root and falloff pipelines to the output register.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds only while the output register is full and not taken.
// The longest paths are one 33x33 multiply, one 62-bit compare-subtract per
// root bit stage and one 48-bit compare-subtract per quotient bit stage.
// Reset clears all valid bits and loads the configuration reset values.
`default_nettype none
module sight_cone_filter_top (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // observer_id, observer_x, observer_z, facing_x, facing_z, target_id,
  // target_x, target_z, target_faction (lowest bit up)
  input  wire [scf_pkg::IN_W-1:0]         s_tdata,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // verdict, confidence, zero fill (lowest bit up)
  output logic [scf_pkg::OUT_W-1:0]       m_tdata,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [scf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [scf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import scf_pkg::*;

  // Configuration registers
  logic [31:0] self_faction, interest_mask;
  logic [30:0] view_range;
  logic [16:0] acuity_raw, floor_raw;
  logic [8:0]  angle_raw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_faction  <= 32'd0;
      interest_mask <= 32'hFFFF_FFFF;
      view_range    <= 31'd0;
      acuity_raw    <= ONE_Q16;
      angle_raw     <= MAX_DEG;
      floor_raw     <= 17'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OWN_FACTION:   self_faction  <= cfg_data;
        REG_INTEREST_MASK: interest_mask <= cfg_data;
        REG_SIGHT_RANGE:   view_range    <= cfg_data[30:0];
        REG_ACUITY:        acuity_raw    <= cfg_data[16:0];
        REG_VIEW_ANGLE:    angle_raw     <= cfg_data[8:0];
        REG_FLOOR_CONF:    floor_raw     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Clamp and derive the cone cosine
  cfg_t        cfg;
  logic [8:0]  deg;
  logic [7:0]  half;
  logic [6:0]  cidx;
  assign deg  = (angle_raw > MAX_DEG) ? MAX_DEG : angle_raw;
  assign half = 8'((deg + 9'd1) >> 1);
  assign cidx = (half <= 8'd90) ? half[6:0] : 7'(8'd180 - half);

  always_comb begin
    cfg.self_faction  = self_faction;
    cfg.interest_mask = interest_mask;
    cfg.view_range    = view_range;
    cfg.acuity        = (acuity_raw > ONE_Q16) ? ONE_Q16 : acuity_raw;
    cfg.floor_conf    = (floor_raw > ONE_Q16) ? ONE_Q16 : floor_raw;
    cfg.cos_mag       = cos_deg_q16(cidx);
    cfg.cos_neg       = (half > 8'd90);
  end

  // Pipeline advances unless the output item is held
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic            f_valid;
  verdict_t        f_verdict;
  logic [SQ_W-1:0] f_sq;

  scf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_data    (s_tdata),
    .out_valid  (f_valid),
    .out_verdict(f_verdict),
    .out_sq     (f_sq)
  );

  logic              r_valid;
  logic [ROOT_W-1:0] r_root;
  logic [1:0]        r_tag;

  scf_isqrt #(
    .VAL_W(SQ_W),
    .TAG_W(2)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (f_valid),
    .in_val   (f_sq),
    .in_tag   (f_verdict),
    .out_valid(r_valid),
    .out_root (r_root),
    .out_tag  (r_tag)
  );

  logic        c_valid;
  verdict_t    c_verdict;
  logic [16:0] c_conf;

  scf_falloff u_falloff (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .cfg        (cfg),
    .in_valid   (r_valid),
    .in_dist    (r_root),
    .in_verdict (verdict_t'(r_tag)),
    .out_valid  (c_valid),
    .out_verdict(c_verdict),
    .out_conf   (c_conf)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) m_tdata <= {5'd0, c_conf, c_verdict};
  end

endmodule
`default_nettype wire
